@@ rtl/cwu_pkg.sv @@
// ----------------------------------------------------------------------------
// cwu_pkg
// Shared constants of the congestion window update unit.
// ----------------------------------------------------------------------------
package cwu_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W     = 2;
  localparam int ACKED_W    = 16;
  localparam int BYTES_W    = 32;
  localparam int SEG_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int CA_W       = 16;
  localparam int THRESH_W   = 32;
  localparam int OUT_WIN_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_CNT_W = $clog2(GAIN_W);

  // Packed stream widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ACKED_W + 2 * BYTES_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = OUT_WIN_W + THRESH_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOSS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEG_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SS_GAIN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CA_STEP  = 2'd2;

  // Reset values
  localparam logic [SEG_W-1:0]    SEG_SIZE_RESET = 16'd536;
  localparam logic [GAIN_W-1:0]   SS_GAIN_RESET  = 32'd163244;
  localparam logic [CA_W-1:0]     CA_STEP_RESET  = 16'd273;
  localparam logic [SEG_W-1:0]    CWND_RESET     = 16'd536;
  localparam logic [THRESH_W-1:0] THRESH_RESET   = '1;

endpackage

@@ rtl/cwu_div.sv @@
// ----------------------------------------------------------------------------
// cwu_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend
// shifted out of the top of a shift register while quotient bits enter below.
// ----------------------------------------------------------------------------
module cwu_div #(
  parameter int DIVISOR_W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cwu_pkg::GAIN_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]        divisor,
  output logic                        done,
  output logic [cwu_pkg::GAIN_W-1:0]  quotient
);

  logic                              busy;
  logic [cwu_pkg::GAIN_CNT_W-1:0]    cnt;
  logic [DIVISOR_W-1:0]              rem;
  logic [cwu_pkg::GAIN_W-1:0]        quo;
  logic [DIVISOR_W:0]                trial;
  logic [DIVISOR_W:0]                diff;
  logic                              qbit;
  logic [DIVISOR_W-1:0]              rem_next;

  always_comb begin
    trial    = {rem, quo[cwu_pkg::GAIN_W-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cwu_pkg::GAIN_CNT_W'(cwu_pkg::GAIN_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[cwu_pkg::GAIN_W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/tcp_congestion_window_update_unit.sv @@
// ----------------------------------------------------------------------------
// tcp_congestion_window_update_unit
// Congestion window and slow-start threshold keeper with serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis: tuser carries the kind (ack, loss, load),
//   tdata carries segments_acked, bytes_in_flight and load_value. Each
//   request yields one response on m_axis with the window, the threshold
//   and the slow-start flag after the update.
//   Registers seg_size, ss_gain and ca_step are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while no
//   request is in progress, as the block itself does not enforce it.
//   An ack in slow start runs the 32-step serial divider for ss_gain /
//   window, adds the quotient, then makes the avoidance check; an ack in
//   congestion avoidance makes only that check; loss, load, unused kinds
//   and acks of zero segments pass straight to the response register.
//   One request is worked on at a time. The response register frees the
//   input side: a new request is accepted while a response waits, and the
//   next response holds in the block until m_axis_tready takes the first.
//   Reset (rst, synchronous) restores the register defaults, sets the
//   window to 536 and the threshold to all ones, and drops any response.
// ----------------------------------------------------------------------------
module tcp_congestion_window_update_unit #(
  parameter int WINDOW_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: segments_acked[15:0], bytes_in_flight[47:16], load_value[79:48]
  input  logic [cwu_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [cwu_pkg::KIND_W-1:0]          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: window[31:0], threshold[63:32], in_slow_start[64], zero pad[71:65]
  output logic [cwu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we,
  input  logic [cwu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cwu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CMP_W = (WINDOW_BITS > cwu_pkg::THRESH_W) ? WINDOW_BITS : cwu_pkg::THRESH_W;
  localparam int SUM_W = CMP_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DISP   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_SS_ADD = 5'b01000,
    ST_CA     = 5'b10000
  } state_t;

  // Response is issued in the PH_OUT phase of ST_DISP, the last step of every request
  typedef enum logic [1:0] {
    PH_WORK = 2'b01,
    PH_OUT  = 2'b10
  } phase_t;

  state_t state;
  phase_t phase;

  logic [cwu_pkg::SEG_W-1:0]    seg_size;
  logic [cwu_pkg::GAIN_W-1:0]   ss_gain;
  logic [cwu_pkg::CA_W-1:0]     ca_step;

  logic [WINDOW_BITS-1:0]       cwnd;
  logic [cwu_pkg::THRESH_W-1:0] ssthresh;

  logic [cwu_pkg::KIND_W-1:0]   kind;
  logic [cwu_pkg::ACKED_W-1:0]  acked;
  logic [cwu_pkg::BYTES_W-1:0]  bif;
  logic [cwu_pkg::BYTES_W-1:0]  load;
  logic                         left_nz;

  logic                         div_start;
  logic                         div_done;
  logic [cwu_pkg::GAIN_W-1:0]   quotient;

  logic [CMP_W-1:0]             cwnd_ext;
  logic [CMP_W-1:0]             thresh_ext;
  logic [CMP_W-1:0]             max_ext;
  logic [CMP_W-1:0]             load_ext;
  logic                         slow;
  logic [cwu_pkg::GAIN_W-1:0]   addend;
  logic [SUM_W-1:0]             sum;
  logic [WINDOW_BITS-1:0]       sat_sum;
  logic [WINDOW_BITS-1:0]       load_win;
  logic [cwu_pkg::THRESH_W-1:0] floor2;
  logic [cwu_pkg::THRESH_W-1:0] half;
  logic [cwu_pkg::THRESH_W-1:0] loss_thresh;
  logic                         out_load;
  logic                         out_free;

  cwu_div #(
    .DIVISOR_W (WINDOW_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ss_gain),
    .divisor  (cwnd),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    cwnd_ext   = CMP_W'(cwnd);
    thresh_ext = CMP_W'(ssthresh);
    max_ext    = CMP_W'({WINDOW_BITS{1'b1}});
    slow       = (cwnd_ext < thresh_ext);

    // Shared saturating adder: slow-start gain or avoidance step
    if (state == ST_SS_ADD) begin
      addend = (cwnd == '0) ? '0 : quotient;
    end else begin
      addend = cwu_pkg::GAIN_W'(ca_step);
    end
    sum = SUM_W'(cwnd) + SUM_W'(addend);
    if (sum > SUM_W'(max_ext)) begin
      sat_sum = '1;
    end else begin
      sat_sum = sum[WINDOW_BITS-1:0];
    end

    // Load of zero becomes one, clamp at window maximum
    load_ext = CMP_W'((load == '0) ? cwu_pkg::BYTES_W'(1) : load);
    if (load_ext > max_ext) begin
      load_win = '1;
    end else begin
      load_win = load_ext[WINDOW_BITS-1:0];
    end

    floor2      = cwu_pkg::THRESH_W'({seg_size, 1'b0});
    half        = {1'b0, bif[cwu_pkg::BYTES_W-1:1]};
    loss_thresh = (floor2 > half) ? floor2 : half;

    out_free  = !m_axis_tvalid || m_axis_tready;
    out_load  = (phase == PH_OUT) && out_free;
    div_start = (state == ST_DISP) && (phase == PH_WORK) && (kind == cwu_pkg::KIND_ACK)
                && (acked != '0) && slow;
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size <= cwu_pkg::SEG_SIZE_RESET;
      ss_gain  <= cwu_pkg::SS_GAIN_RESET;
      ca_step  <= cwu_pkg::CA_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cwu_pkg::REG_SEG_SIZE: seg_size <= cfg_data[cwu_pkg::SEG_W-1:0];
        cwu_pkg::REG_SS_GAIN:  ss_gain  <= cfg_data[cwu_pkg::GAIN_W-1:0];
        cwu_pkg::REG_CA_STEP:  ca_step  <= cfg_data[cwu_pkg::CA_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind  <= s_axis_tuser;
      acked <= s_axis_tdata[cwu_pkg::ACKED_W-1:0];
      bif   <= s_axis_tdata[cwu_pkg::ACKED_W +: cwu_pkg::BYTES_W];
      load  <= s_axis_tdata[cwu_pkg::ACKED_W + cwu_pkg::BYTES_W +: cwu_pkg::BYTES_W];
    end
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_WORK;
      cwnd     <= WINDOW_BITS'(cwu_pkg::CWND_RESET);
      ssthresh <= cwu_pkg::THRESH_RESET;
      left_nz  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_DISP;
            phase <= PH_WORK;
          end
        end
        ST_DISP: begin
          if (phase == PH_OUT) begin
            if (out_load) begin
              state <= ST_IDLE;
              phase <= PH_WORK;
            end
          end else begin
            case (kind)
              cwu_pkg::KIND_ACK: begin
                if (acked == '0) begin
                  phase <= PH_OUT;
                end else if (slow) begin
                  left_nz <= (acked != cwu_pkg::ACKED_W'(1));
                  state   <= ST_DIV;
                end else begin
                  left_nz <= 1'b1;
                  state   <= ST_CA;
                end
              end
              cwu_pkg::KIND_LOSS: begin
                ssthresh <= loss_thresh;
                phase    <= PH_OUT;
              end
              cwu_pkg::KIND_LOAD: begin
                cwnd  <= load_win;
                phase <= PH_OUT;
              end
              default: phase <= PH_OUT;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SS_ADD;
          end
        end
        ST_SS_ADD: begin
          cwnd  <= sat_sum;
          state <= ST_CA;
        end
        ST_CA: begin
          // Avoidance step only once at or past threshold with segments left
          if (!slow && left_nz) begin
            cwnd <= sat_sum;
          end
          state <= ST_DISP;
          phase <= PH_OUT;
        end
        default: begin
          state <= ST_IDLE;
          phase <= PH_WORK;
        end
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= cwu_pkg::OUT_DATA_W'({slow, ssthresh, cwu_pkg::OUT_WIN_W'(cwnd)});
    end
  end

endmodule
